>>> rtl/wle_pkg.sv
// wle_pkg: shared constants, codes, sequencer states and transaction structs
// for the word list engine. No dependencies.
package wle_pkg;

   // List capacity and the widths that follow from it
   localparam int DEPTH = 64;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = 6;
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_POP    = 2'd1,
      CMD_ERASE  = 2'd2,
      CMD_FIND   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_OK    = 3'd0,
      STAT_FULL  = 3'd1,
      STAT_EMPTY = 3'd2,
      STAT_RANGE = 3'd3,
      STAT_MISS  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_POP_WAIT,
      S_ER_WAIT,
      S_SH_RD,
      S_SH_WR,
      S_SC_RD,
      S_SC_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      cmd_type           command;
      logic [31:0]       value;
      logic [IDX_W-1:0]  index;
   } req_type;

   typedef struct packed {
      logic [31:0]       word_out;
      logic [5:0]        position;
      status_type        status;
      logic [6:0]        count_after;
   } rsp_type;

endpackage

>>> rtl/word_list_engine.sv
// word_list_engine: bounded ordered list of 32-bit words with append, pop,
// erase-at-index and find. Single module with the element RAM inside.
// Depends on wle_pkg.
//
//  channel | ports                              | direction | payload
//  --------+------------------------------------+-----------+-------------------------
//  request | req_valid, req_stall, req_payload  | in        | command, value, index
//  response| rsp_valid, rsp_stall, rsp_payload  | out       | word_out, position,
//          |                                    |           | status, count_after
//
// One transaction at a time. req_stall is high from acceptance until the
// result is loaded into the response register, so the next transaction can be
// taken while that result still waits for the consumer.
// Steps: append writes in S_EXEC; pop reads the tail there and takes the word
//   in S_POP_WAIT; find reads and compares each word from the head until a hit
//   or the tail; erase reads the word at index, then shifts each later word down.
//   Full, empty, out-of-range and empty-list finds go to S_DONE. Erase and find use the
//   single RAM port pair and one comparator; each word is read, then used registered.
// Reset (synchronous) empties the list; RAM contents are not cleared since
// no entry at or beyond the count is ever read.
// A stalled response holds the sequencer in its final state until accepted.
module word_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wle_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wle_pkg::rsp_type rsp_payload
);
   import wle_pkg::*;

   // Element RAM
   logic [31:0]       mem [DEPTH];
   logic [31:0]       rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [31:0]       mem_wdata;

   // Sequencer and datapath registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   cmd_type           cmd_ff, cmd_in;
   logic [31:0]       value_ff, value_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [31:0]       word_ff, word_in;
   logic [5:0]        pos_ff, pos_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // Conditions
   logic req_take;
   logic rsp_free;
   logic is_full;
   logic is_empty;
   logic idx_bad;
   logic er_last;
   logic sh_last;
   logic sc_last;
   logic hit;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign is_full   = (count_ff >= CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign idx_bad   = (CMP_W'(index_ff) >= CMP_W'(count_ff));
   assign er_last   = ((CNT_W'(ptr_ff) + CNT_W'(1)) >= count_ff);
   assign sh_last   = ((CNT_W'(ptr_ff) + CNT_W'(2)) >= count_ff);
   assign sc_last   = ((CNT_W'(ptr_ff) + CNT_W'(1)) >= count_ff);
   assign hit       = (rd_data_ff == value_ff);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (cmd_ff)
               CMD_APPEND: state_in = S_DONE;
               CMD_POP:    state_in = is_empty ? S_DONE : S_POP_WAIT;
               CMD_ERASE:  state_in = idx_bad ? S_DONE : S_ER_WAIT;
               CMD_FIND:   state_in = is_empty ? S_DONE : S_SC_RD;
            endcase
         end
         S_POP_WAIT: state_in = S_DONE;
         S_ER_WAIT:  state_in = er_last ? S_DONE : S_SH_RD;
         S_SH_RD:    state_in = S_SH_WR;
         S_SH_WR:    state_in = sh_last ? S_DONE : S_SH_RD;
         S_SC_RD:    state_in = S_SC_CMP;
         S_SC_CMP:   state_in = (hit || sc_last) ? S_DONE : S_SC_RD;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath control
   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      index_in     = index_ff;
      word_in      = word_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = ADDR_W'(count_ff);
      mem_wdata    = value_ff;
      mem_raddr    = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in    = req_payload.command;
               value_in  = req_payload.value;
               index_in  = req_payload.index;
               word_in   = '0;
               pos_in    = '0;
               status_in = STAT_OK;
            end
         end
         S_EXEC: begin
            unique case (cmd_ff)
               CMD_APPEND: begin
                  if (is_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_POP: begin
                  if (is_empty) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     count_in  = count_ff - CNT_W'(1);
                     mem_raddr = ADDR_W'(count_ff - CNT_W'(1));
                  end
               end
               CMD_ERASE: begin
                  if (idx_bad) begin
                     status_in = STAT_RANGE;
                  end else begin
                     mem_raddr = ADDR_W'(index_ff);
                     ptr_in    = ADDR_W'(index_ff);
                  end
               end
               CMD_FIND: begin
                  if (is_empty) begin
                     status_in = STAT_MISS;
                  end else begin
                     ptr_in = '0;
                  end
               end
            endcase
         end
         S_POP_WAIT: word_in = rd_data_ff;
         S_ER_WAIT: begin
            word_in = rd_data_ff;
            if (er_last) count_in = count_ff - CNT_W'(1);
         end
         S_SH_RD: mem_raddr = ptr_ff + ADDR_W'(1);
         S_SH_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rd_data_ff;
            ptr_in    = ptr_ff + ADDR_W'(1);
            if (sh_last) count_in = count_ff - CNT_W'(1);
         end
         S_SC_RD: mem_raddr = ptr_ff;
         S_SC_CMP: begin
            if (hit) begin
               pos_in = 6'(ptr_ff);
            end else if (sc_last) begin
               status_in = STAT_MISS;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.word_out     = word_ff;
               rsp_in.position     = pos_ff;
               rsp_in.status       = status_ff;
               rsp_in.count_after  = 7'(count_ff);
            end
         end
         default: ;
      endcase
   end

   // Element RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      cmd_ff    <= cmd_in;
      value_ff  <= value_in;
      index_ff  <= index_in;
      word_ff   <= word_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

endmodule

>>> test/wle_checker.sv
// wle_checker: watches both channels of word_list_engine, predicts every
// result from an internal copy of the list and compares field by field.
// Depends on wle_pkg.
module wle_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  wle_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  wle_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               open_count
);
   import wle_pkg::*;

   logic [31:0] list_words[$];   // shadow list, index 0 is the head
   rsp_type     due_q[$];        // predicted results, oldest first
   int          fail_tally = 0;

   assign fail_count = fail_tally;

   // Apply one command to the shadow list and return its result.
   function automatic rsp_type apply_cmd(req_type item);
      rsp_type res;
      int      hit;
      res = '0;
      res.status = STAT_OK;
      hit = -1;
      case (item.command)
         CMD_APPEND: begin
            if (list_words.size() >= DEPTH) res.status = STAT_FULL;
            else list_words.push_back(item.value);
         end
         CMD_POP: begin
            if (list_words.size() == 0) res.status = STAT_EMPTY;
            else res.word_out = list_words.pop_back();
         end
         CMD_ERASE: begin
            if (int'(item.index) >= list_words.size()) begin
               res.status = STAT_RANGE;
            end else begin
               res.word_out = list_words[item.index];
               list_words.delete(int'(item.index));
            end
         end
         default: begin
            for (int i = 0; i < list_words.size(); i++) begin
               if (list_words[i] == item.value) begin
                  hit = i;
                  break;
               end
            end
            if (hit < 0) res.status = STAT_MISS;
            else res.position = hit[5:0];
         end
      endcase
      res.count_after = 7'(list_words.size());
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         list_words.delete();
         due_q.delete();
         open_count <= 0;
      end else begin
         // Result side first: a result never belongs to a request taken
         // at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               if (fail_tally < 10)
                  $display("[%0t] unexpected result: word %h pos %0d status %0d count %0d",
                           $realtime, rsp_payload.word_out, rsp_payload.position,
                           rsp_payload.status, rsp_payload.count_after);
               fail_tally++;
            end else begin
               want = due_q.pop_front();
               if (rsp_payload.word_out !== want.word_out ||
                   rsp_payload.position !== want.position ||
                   rsp_payload.status !== want.status ||
                   rsp_payload.count_after !== want.count_after) begin
                  if (fail_tally < 10)
                     $display({"[%0t] mismatch: word %h/%h pos %0d/%0d status %0d/%0d ",
                               "count %0d/%0d (expected/actual)"}, $realtime,
                              want.word_out, rsp_payload.word_out,
                              want.position, rsp_payload.position,
                              want.status, rsp_payload.status,
                              want.count_after, rsp_payload.count_after);
                  fail_tally++;
               end
            end
         end
         if (req_valid && !req_stall) due_q.push_back(apply_cmd(req_payload));
         open_count <= due_q.size();
      end
   end

endmodule

>>> test/tb_top.sv
// tb_top: stimulus and verdict for word_list_engine. The checker instance
// does all prediction and comparison; this module only drives traffic.
// Depends on wle_pkg, word_list_engine and wle_checker.
module tb_top;
   import wle_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   // Longest legal quiet stretch: a full-depth find, a long
   // receiver stall and a sender gap; taken well over that.
   localparam int STALL_LIMIT  = 4000;
   localparam int TAIL_CYCLES  = 200;    // covers the slowest transaction

   // Traffic mixes for the random part
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_NOISE} mix_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int fail_count;
   int open_count;                 // results still owed, as of the last edge

   int          fill_level   = 0;  // list length implied by the commands sent
   int          burst_left   = 1;  // transactions left in the current burst
   int          quiet_cycles = 0;
   logic [31:0] word_pool[8];      // recurring words so that finds hit

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   word_list_engine i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   wle_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .open_count  (open_count)
   );

   // ---------------------------------------------------------------------
   // Receiver back-pressure. The pattern changes every segment: no stall,
   // coin-flip stall, rare stall, or long alternating stall/open runs.
   // ---------------------------------------------------------------------
   int stall_mode = 0;
   int seg_left   = 0;
   int hold_left  = 0;

   always @(posedge clock) begin
      if (seg_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         seg_left   <= $urandom_range(16, 256);
      end else begin
         seg_left <= seg_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 7) == 0);
         default: begin
            if (hold_left == 0) begin
               hold_left <= $urandom_range(2, 40);
               rsp_stall <= !rsp_stall;
            end else begin
               hold_left <= hold_left - 1;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Watchdog: any accepted transaction on either channel resets the count.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("word_list_engine verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_req(cmd_type cmd, logic [31:0] word, logic [5:0] idx);
      req_type item;
      item.command = cmd;
      item.value   = word;
      item.index   = idx;
      return item;
   endfunction

   // Present one transaction and hold it until accepted. Afterwards the burst
   // may end, in which case valid drops for a random gap. Valid is never
   // lowered and raised within the same edge.
   task automatic issue_cmd(input req_type item);
      int gap;
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      // Length bookkeeping is all the stimulus needs to aim erase indexes.
      case (item.command)
         CMD_APPEND: if (fill_level < DEPTH) fill_level++;
         CMD_POP:    if (fill_level > 0) fill_level--;
         CMD_ERASE:  if (int'(item.index) < fill_level) fill_level--;
         default: ;
      endcase
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
         // Mostly short bursts, now and then a long unbroken stretch.
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 20);
      end
   endtask

   // Stop sending until every owed result has been taken.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   // Build one random command. Outside the noise mix, erase mostly aims
   // inside the list and finds mostly look for words that were appended.
   function automatic req_type pick_cmd(mix_type mix);
      req_type item;
      int      roll;
      cmd_type cmd;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  cmd = (roll < 70) ? CMD_APPEND : (roll < 80) ? CMD_POP :
                          (roll < 90) ? CMD_ERASE  : CMD_FIND;
         MIX_DRAIN: cmd = (roll < 15) ? CMD_APPEND : (roll < 50) ? CMD_POP :
                          (roll < 80) ? CMD_ERASE  : CMD_FIND;
         MIX_EVEN:  cmd = cmd_type'(roll[1:0]);
         default:   cmd = cmd_type'($urandom_range(0, 3));
      endcase
      item = make_req(cmd, $urandom(), 6'($urandom_range(0, 63)));
      if (mix != MIX_NOISE) begin
         if (cmd == CMD_ERASE && fill_level > 0 && $urandom_range(0, 3) != 0)
            item.index = 6'($urandom_range(0, fill_level - 1));
         if ((cmd == CMD_APPEND && $urandom_range(0, 1) == 1) ||
             (cmd == CMD_FIND && $urandom_range(0, 9) < 7))
            item.value = word_pool[$urandom_range(0, 7)];
      end
      return item;
   endfunction

   initial begin
      mix_type mix;
      int      seg_len;
      int      sent;

      word_pool[0] = 32'h0000_0000;
      word_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) word_pool[i] = $urandom();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: empty-list errors, duplicates, range edges, shifting ---
      issue_cmd(make_req(CMD_POP,    32'h0,         6'd0));   // pop when empty
      issue_cmd(make_req(CMD_ERASE,  32'h0,         6'd0));   // erase on empty list
      issue_cmd(make_req(CMD_ERASE,  32'hFFFF_FFFF, 6'd63));
      issue_cmd(make_req(CMD_FIND,   32'h0,         6'd0));   // find on empty list
      issue_cmd(make_req(CMD_APPEND, 32'h0000_0000, 6'd63));  // index ignored
      issue_cmd(make_req(CMD_APPEND, 32'hFFFF_FFFF, 6'd0));
      issue_cmd(make_req(CMD_APPEND, 32'hA5A5_A5A5, 6'd0));
      issue_cmd(make_req(CMD_APPEND, 32'h0000_0000, 6'd0));   // duplicate word
      issue_cmd(make_req(CMD_APPEND, 32'h5A5A_5A5A, 6'd0));
      issue_cmd(make_req(CMD_FIND,   32'h0000_0000, 6'd63));  // lowest of two hits
      issue_cmd(make_req(CMD_FIND,   32'hFFFF_FFFF, 6'd0));
      issue_cmd(make_req(CMD_FIND,   32'h5A5A_5A5A, 6'd0));   // hit at the tail
      issue_cmd(make_req(CMD_FIND,   32'h1234_5678, 6'd0));   // no match
      issue_cmd(make_req(CMD_ERASE,  32'h0,         6'd5));   // index == count
      issue_cmd(make_req(CMD_ERASE,  32'h0,         6'd63));
      issue_cmd(make_req(CMD_ERASE,  32'h0,         6'd0));   // head, shifts all
      issue_cmd(make_req(CMD_FIND,   32'h0000_0000, 6'd0));   // duplicate moved down
      issue_cmd(make_req(CMD_ERASE,  32'h0,         6'd3));   // last entry
      issue_cmd(make_req(CMD_POP,    32'hFFFF_FFFF, 6'd63));
      issue_cmd(make_req(CMD_POP,    32'h0,         6'd0));
      issue_cmd(make_req(CMD_POP,    32'h0,         6'd0));
      issue_cmd(make_req(CMD_POP,    32'h0,         6'd0));   // pop on the empty list again

      // Let the directed traffic settle completely once.
      hold_until_drained();

      // --- random: segments of one mix; the first one fills to full ---
      sent = 0;
      mix = MIX_FILL;
      seg_len = 200;
      while (sent < RANDOM_ITEMS) begin
         for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
            issue_cmd(pick_cmd(mix));
            sent++;
         end
         if ($urandom_range(0, 5) == 0) hold_until_drained();
         mix = mix_type'($urandom_range(0, 3));
         seg_len = (mix == MIX_FILL || mix == MIX_DRAIN) ? $urandom_range(80, 200)
                                                          : $urandom_range(20, 150);
      end

      // Wait for the last results, then give the block time to show
      // anything spurious.
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && open_count == 0) begin
         $display("word_list_engine verification clean");
      end else begin
         $display("word_list_engine verification failed");
      end
      $finish;
   end

endmodule
